// ===== hw/rtl/second_order_pose_filter_top_macros.svh =====
// Assertion macros for the pose filter checker.
// Standalone header; the bound checker includes it.
`ifndef SECOND_ORDER_POSE_FILTER_TOP_MACROS_SVH
`define SECOND_ORDER_POSE_FILTER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define SOPF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pose filter check failed");

// next-cycle implication, disabled in reset
`define SOPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pose filter check failed");

`endif

// ===== hw/rtl/sopf_pkg.sv =====
// Shared constants, types and helpers for the second-order pose filter.
// No dependencies.
package sopf_pkg;

  localparam int AXES       = 3;
  localparam int DATA_WIDTH = 32;
  localparam int CFG_WIDTH  = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int AXIS_W     = (AXES > 1) ? $clog2(AXES) : 1;

  localparam int SHIFT_GAIN = 16;
  localparam int SHIFT_TS   = 32;

  localparam int MUL_A_W = DATA_WIDTH + 1;
  localparam int MUL_B_W = CFG_WIDTH;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int TERM_W  = PROD_W - SHIFT_GAIN;
  localparam int ACC_W   = TERM_W + 1;
  localparam int STEP_W  = PROD_W - SHIFT_TS;
  localparam int SUM_W   = STEP_W + 1;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic [CFG_WIDTH-1:0]         cfg_word_t;
  typedef logic [CFG_ADDR_W-1:0]        cfg_addr_t;

  localparam cfg_addr_t REG_OMEGA_SQ      = 2'd0;
  localparam cfg_addr_t REG_DAMPING_TERM  = 2'd1;
  localparam cfg_addr_t REG_SAMPLE_PERIOD = 2'd2;

  localparam cfg_word_t OMEGA_SQ_RST      = 32'd163840000;
  localparam cfg_word_t DAMPING_TERM_RST  = 32'd6553600;
  localparam cfg_word_t SAMPLE_PERIOD_RST = 32'd85899346;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_GAIN,
    ST_MUL_DAMP,
    ST_ACC,
    ST_MUL_VEL,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  localparam logic signed [ACC_W-1:0] WORD_MAX_X =
    {{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] WORD_MIN_X =
    {{(ACC_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  function automatic word_t sat_word(input logic signed [ACC_W-1:0] x);
    word_t r;
    if (x > WORD_MAX_X) begin
      r = WORD_MAX_X[DATA_WIDTH-1:0];
    end else if (x < WORD_MIN_X) begin
      r = WORD_MIN_X[DATA_WIDTH-1:0];
    end else begin
      r = x[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/second_order_pose_filter_top.sv =====
// Second-order pose filter: three axes, one shared multiplier, small sequencer.
// Depends on sopf_pkg.
//
// Usage:
//   cfg_we/cfg_addr/cfg_wdata write omega_sq (0), damping_term (1) and
//   sample_period (2); other indexes are ignored. Write only
//   while the block is idle.
//   Input channel in_valid/in_ready carries one position sample (pos_x/y/z).
//   Output channel out_valid/out_ready carries est, vel and acc per axis.
// Sequence:
//   Each axis steps through MUL_GAIN, MUL_DAMP, ACC, MUL_VEL and UPDATE,
//   making four products on the one 33x32 multiplier, with the
//   add/saturate steps overlapped. After the last axis, FINISH loads the
//   output register once it is free: the result turns valid and in_ready
//   is back together.
//   in_ready is low while an item is being worked on.
// Stall:
//   The output register holds a result until it is taken; the next item
//   may be accepted meanwhile and waits finished until the register frees.
// Reset:
//   rst (synchronous) clears filter state to zero, restores register
//   defaults and drops out_valid.
module second_order_pose_filter_top
  import sopf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  cfg_addr_t cfg_addr,
  input  cfg_word_t cfg_wdata,
  input  logic      in_valid,
  output logic      in_ready,
  input  word_t     pos_x,
  input  word_t     pos_y,
  input  word_t     pos_z,
  output logic      out_valid,
  input  logic      out_ready,
  output word_t     est_x,
  output word_t     est_y,
  output word_t     est_z,
  output word_t     vel_x,
  output word_t     vel_y,
  output word_t     vel_z,
  output word_t     acc_x,
  output word_t     acc_y,
  output word_t     acc_z
);

  state_t state, state_next;

  cfg_word_t omega_sq, damping_term, sample_period;

  word_t u       [AXES];
  word_t q0      [AXES];
  word_t q1      [AXES];
  word_t res_est [AXES];
  word_t res_vel [AXES];
  word_t res_acc [AXES];
  word_t out_est [AXES];
  word_t out_vel [AXES];
  word_t out_acc [AXES];

  logic [AXIS_W-1:0] axis;
  logic              last_axis;
  logic              slot_free;

  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  prod_full;
  logic signed [PROD_W-1:0]  prod;
  logic signed [TERM_W-1:0]  gain_term;
  logic signed [TERM_W-1:0]  prod_gain;
  logic signed [STEP_W-1:0]  prod_step;
  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [SUM_W-1:0]   pos_sum;
  logic signed [SUM_W-1:0]   vel_sum;
  word_t                     acc_r;
  word_t                     acc_sat;

  word_t u_cur, q0_cur, q1_cur;
  logic signed [MUL_A_W-1:0] diff;

  assign u_cur  = u[axis];
  assign q0_cur = q0[axis];
  assign q1_cur = q1[axis];

  assign diff = {u_cur[DATA_WIDTH-1], u_cur} - {q0_cur[DATA_WIDTH-1], q0_cur};

  assign last_axis = (axis == AXIS_W'(AXES - 1));
  assign slot_free = !out_valid || out_ready;

  // shared multiplier, floor shifts taken as upper bits
  assign prod_full = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));
  assign prod_gain = prod[PROD_W-1:SHIFT_GAIN];
  assign prod_step = prod[PROD_W-1:SHIFT_TS];

  assign acc_sum = {gain_term[TERM_W-1], gain_term} - {prod_gain[TERM_W-1], prod_gain};
  assign acc_sat = sat_word(acc_sum);

  assign pos_sum = {prod_step[STEP_W-1], prod_step}
                 + {{(SUM_W-DATA_WIDTH){q0_cur[DATA_WIDTH-1]}}, q0_cur};
  assign vel_sum = {prod_step[STEP_W-1], prod_step}
                 + {{(SUM_W-DATA_WIDTH){q1_cur[DATA_WIDTH-1]}}, q1_cur};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_MUL_GAIN;
      ST_MUL_GAIN: state_next = ST_MUL_DAMP;
      ST_MUL_DAMP: state_next = ST_ACC;
      ST_ACC:      state_next = ST_MUL_VEL;
      ST_MUL_VEL:  state_next = ST_UPDATE;
      ST_UPDATE:   state_next = last_axis ? ST_FINISH : ST_MUL_GAIN;
      ST_FINISH:   if (slot_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mul_a    = {q1_cur[DATA_WIDTH-1], q1_cur};
    mul_b    = sample_period;
    unique case (state)
      ST_IDLE:     in_ready = 1'b1;
      ST_MUL_GAIN: begin
        mul_a = diff;
        mul_b = omega_sq;
      end
      ST_MUL_DAMP: mul_b = damping_term;
      ST_MUL_VEL:  mul_a = {acc_r[DATA_WIDTH-1], acc_r};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      omega_sq      <= OMEGA_SQ_RST;
      damping_term  <= DAMPING_TERM_RST;
      sample_period <= SAMPLE_PERIOD_RST;
      for (int i = 0; i < AXES; i++) begin
        q0[i] <= '0;
        q1[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_addr)
          REG_OMEGA_SQ:      omega_sq      <= cfg_wdata;
          REG_DAMPING_TERM:  damping_term  <= cfg_wdata;
          REG_SAMPLE_PERIOD: sample_period <= cfg_wdata;
          default: ;
        endcase
      end

      if (state == ST_FINISH && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (state == ST_MUL_VEL) q0[axis] <= sat_word(ACC_W'(pos_sum));
      if (state == ST_UPDATE)  q1[axis] <= sat_word(ACC_W'(vel_sum));
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_full;

    if (state == ST_IDLE && in_valid) begin
      u[0] <= pos_x;
      u[1] <= pos_y;
      u[2] <= pos_z;
      axis <= '0;
    end

    if (state == ST_MUL_DAMP) gain_term <= prod_gain;

    if (state == ST_ACC) begin
      acc_r         <= acc_sat;
      res_est[axis] <= q0_cur;
      res_vel[axis] <= q1_cur;
      res_acc[axis] <= acc_sat;
    end

    if (state == ST_UPDATE && !last_axis) axis <= axis + AXIS_W'(1);

    if (state == ST_FINISH && slot_free) begin
      for (int i = 0; i < AXES; i++) begin
        out_est[i] <= res_est[i];
        out_vel[i] <= res_vel[i];
        out_acc[i] <= res_acc[i];
      end
    end
  end

  assign est_x = out_est[0];
  assign est_y = out_est[1];
  assign est_z = out_est[2];
  assign vel_x = out_vel[0];
  assign vel_y = out_vel[1];
  assign vel_z = out_vel[2];
  assign acc_x = out_acc[0];
  assign acc_y = out_acc[1];
  assign acc_z = out_acc[2];

endmodule

// ===== hw/rtl/sopf_checker.sv =====
// Port-level checks for the pose filter, bound to the top level.
// Depends on sopf_pkg and second_order_pose_filter_top_macros.svh.
`include "second_order_pose_filter_top_macros.svh"

module sopf_checker
  import sopf_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input word_t     est_x,
  input word_t     est_y,
  input word_t     est_z,
  input word_t     vel_x,
  input word_t     vel_y,
  input word_t     vel_z,
  input word_t     acc_x,
  input word_t     acc_y,
  input word_t     acc_z
);

  // busy right after an input transfer
  `SOPF_ASSERT_NEXT(a_busy_after_in, clk, rst, in_valid && in_ready, !in_ready)

  // ready only returns together with a loaded result
  `SOPF_ASSERT_SAME(a_ready_with_result, clk, rst, $rose(in_ready) && !$past(rst), out_valid)

  `SOPF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  `SOPF_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready,
                    $stable(est_x) && $stable(est_y) && $stable(est_z) && $stable(vel_x) && $stable(vel_y) && $stable(vel_z) && $stable(acc_x) && $stable(acc_y) && $stable(acc_z))

endmodule

bind second_order_pose_filter_top sopf_checker u_sopf_checker (.*);

// ===== verif/pose_filter_checker.sv =====
// Checker for the second-order pose filter: watches the config, input and output ports,
// predicts est/vel/acc per axis and compares every output transfer in order.
// Depends on sopf_pkg.
module pose_filter_checker
  import sopf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  cfg_addr_t cfg_addr,
  input  cfg_word_t cfg_wdata,
  input  logic      in_valid,
  input  logic      in_ready,
  input  word_t     pos_x,
  input  word_t     pos_y,
  input  word_t     pos_z,
  input  logic      out_valid,
  input  logic      out_ready,
  input  word_t     est_x,
  input  word_t     est_y,
  input  word_t     est_z,
  input  word_t     vel_x,
  input  word_t     vel_y,
  input  word_t     vel_z,
  input  word_t     acc_x,
  input  word_t     acc_y,
  input  word_t     acc_z,
  output int        estimates_due,
  output int        mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [79:0] wide_t;

  typedef struct {
    word_t est [AXES];
    word_t vel [AXES];
    word_t acc [AXES];
  } estimate_t;

  localparam wide_t WORD_HI = 80'sd2147483647;
  localparam wide_t WORD_LO = -80'sd2147483648;

  cfg_word_t omega_sq_cfg;
  cfg_word_t damping_cfg;
  cfg_word_t period_cfg;
  word_t     filt_pos [AXES];
  word_t     filt_vel [AXES];
  estimate_t pending_estimates [$];
  string     axis_tag [AXES] = '{"x", "y", "z"};

  function automatic word_t clamp_word(input wide_t x);
    if (x > WORD_HI) return WORD_HI[DATA_WIDTH-1:0];
    if (x < WORD_LO) return WORD_LO[DATA_WIDTH-1:0];
    return x[DATA_WIDTH-1:0];
  endfunction

  // floor(value * gain / 2^shift), full product kept
  function automatic wide_t scaled(input wide_t value, input cfg_word_t gain,
                                   input int unsigned shift);
    return (value * $signed({48'd0, gain})) >>> shift;
  endfunction

  // outputs come from the state before the update
  function automatic estimate_t filter_step(input word_t sample [AXES]);
    wide_t     u;
    wide_t     q0;
    wide_t     q1;
    wide_t     acc_w;
    word_t     acc;
    estimate_t r;
    for (int a = 0; a < AXES; a++) begin
      u  = sample[a];
      q0 = filt_pos[a];
      q1 = filt_vel[a];
      acc = clamp_word(scaled(u - q0, omega_sq_cfg, SHIFT_GAIN)
                       - scaled(q1, damping_cfg, SHIFT_GAIN));
      acc_w = acc;
      r.est[a] = filt_pos[a];
      r.vel[a] = filt_vel[a];
      r.acc[a] = acc;
      filt_pos[a] = clamp_word(q0 + scaled(q1, period_cfg, SHIFT_TS));
      filt_vel[a] = clamp_word(q1 + scaled(acc_w, period_cfg, SHIFT_TS));
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input word_t want,
                                      input word_t seen);
    if (seen !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, seen);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    estimate_t expd;
    estimate_t got;
    word_t     sample [AXES];
    if (rst) begin
      omega_sq_cfg = OMEGA_SQ_RST;
      damping_cfg  = DAMPING_TERM_RST;
      period_cfg   = SAMPLE_PERIOD_RST;
      for (int a = 0; a < AXES; a++) begin
        filt_pos[a] = '0;
        filt_vel[a] = '0;
      end
      pending_estimates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_OMEGA_SQ:      omega_sq_cfg = cfg_wdata;
          REG_DAMPING_TERM:  damping_cfg  = cfg_wdata;
          REG_SAMPLE_PERIOD: period_cfg   = cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        sample = '{pos_x, pos_y, pos_z};
        pending_estimates.push_back(filter_step(sample));
      end
      if (out_valid && out_ready) begin
        if (pending_estimates.size() == 0) begin
          $error("output transfer with no sample outstanding");
          mismatch_count++;
        end else begin
          expd = pending_estimates.pop_front();
          got.est = '{est_x, est_y, est_z};
          got.vel = '{vel_x, vel_y, vel_z};
          got.acc = '{acc_x, acc_y, acc_z};
          for (int a = 0; a < AXES; a++) begin
            check_field({"est_", axis_tag[a]}, expd.est[a], got.est[a]);
            check_field({"vel_", axis_tag[a]}, expd.vel[a], got.vel[a]);
            check_field({"acc_", axis_tag[a]}, expd.acc[a], got.acc[a]);
          end
        end
      end
    end
    estimates_due <= pending_estimates.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for second_order_pose_filter_top: clock, reset, register writes,
// position samples and output back-pressure; pose_filter_checker does the checking.
// Depends on sopf_pkg, second_order_pose_filter_top and pose_filter_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sopf_pkg::*;

  localparam int        CYCLE_LIMIT    = 400000;
  localparam int        HOLD_CYCLES    = 200;
  localparam int        PHASE_SEGMENTS = 5;
  localparam int        SEGMENT_ITEMS  = 46;
  localparam int        BURST_ITEMS    = 8;
  localparam cfg_addr_t REG_UNUSED     = 2'd3;
  localparam word_t     W_MAX          = 32'h7FFF_FFFF;
  localparam word_t     W_MIN          = 32'h8000_0000;
  localparam word_t     ONE_M          = 32'h0001_0000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cfg_we    = 1'b0;
  cfg_addr_t cfg_addr  = '0;
  cfg_word_t cfg_wdata = '0;
  logic      in_valid  = 1'b0;
  word_t     pos_x     = '0;
  word_t     pos_y     = '0;
  word_t     pos_z     = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  word_t     est_x, est_y, est_z;
  word_t     vel_x, vel_y, vel_z;
  word_t     acc_x, acc_y, acc_z;
  int        estimates_due;
  int        mismatch_count;

  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  logic  hold_req      = 1'b0;
  logic  hold_ack      = 1'b0;
  int    hold_left     = 0;
  int    cycle_count   = 0;
  word_t held [AXES]   = '{'0, '0, '0};

  second_order_pose_filter_top DUT (.*);
  pose_filter_checker checker_i (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_sample(input word_t x, input word_t y, input word_t z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x    <= x;
    pos_y    <= y;
    pos_z    <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic word_t random_coord();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) return word_t'(int'($urandom_range(2097152)) - 1048576);
    if (sel < 80) return word_t'($urandom);
    if (sel < 92) begin
      case ($urandom_range(3))
        0:       return W_MAX;
        1:       return W_MIN;
        2:       return '0;
        default: return -1;
      endcase
    end
    if (sel < 96) return W_MAX - word_t'($urandom_range(255));
    return W_MIN + word_t'($urandom_range(255));
  endfunction

  // new target now and then, otherwise the filter tracks a held step
  task automatic send_random();
    if ($urandom_range(3) == 0) begin
      for (int a = 0; a < AXES; a++) held[a] = random_coord();
    end
    send_sample(held[0], held[1], held[2]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (estimates_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_filter(input cfg_word_t omega, input cfg_word_t damp,
                            input cfg_word_t period, input bit poke_unused);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_OMEGA_SQ;
    cfg_wdata <= omega;
    @(posedge clk);
    cfg_addr  <= REG_DAMPING_TERM;
    cfg_wdata <= damp;
    @(posedge clk);
    cfg_addr  <= REG_SAMPLE_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    if (poke_unused || $urandom_range(3) == 0) begin
      cfg_addr  <= REG_UNUSED;
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_settings();
    case ($urandom_range(9))
      0: set_filter(OMEGA_SQ_RST, DAMPING_TERM_RST, SAMPLE_PERIOD_RST, 1'b0);
      1: set_filter('1, '1, '1, 1'b0);
      2: set_filter('0, '0, '0, 1'b0);
      3: set_filter($urandom, $urandom, $urandom, 1'b0);
      default: set_filter($urandom_range(32'h4000_0000, 32'h0001_0000),
                          $urandom_range(32'h0400_0000),
                          $urandom_range(32'h1000_0000), 1'b0);
    endcase
  endtask

  initial begin
    int saved_idle;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: extremes, zero, minus one, unit steps
    send_sample(W_MAX, W_MIN, '0);
    send_sample(W_MIN, W_MAX, -1);
    send_sample('0, '0, '0);
    send_sample(-1, -1, -1);
    repeat (3) send_sample(ONE_M, ONE_M, ONE_M);
    send_sample(-ONE_M, ONE_M, W_MAX);
    drain();
    // all gains at max: acc and state saturate, unused index ignored
    set_filter('1, '1, '1, 1'b1);
    send_sample(W_MAX, W_MIN, W_MAX);
    send_sample(W_MIN, W_MAX, '0);
    send_sample(W_MAX, W_MAX, W_MIN);
    send_sample('0, -1, 1);
    drain();
    // zero gains: state frozen
    set_filter('0, '0, '0, 1'b0);
    send_sample(W_MAX, W_MIN, ONE_M);
    send_sample('0, '0, '0);
    drain();
    set_filter('1, '0, '1, 1'b0);
    send_sample(ONE_M, -ONE_M, W_MIN);
    send_sample(W_MIN, W_MAX, '0);
    drain();
    set_filter('0, '1, 32'h0100_0000, 1'b0);
    send_sample(ONE_M, W_MAX, W_MIN);
    send_sample('0, '0, '0);
    drain();
    set_filter(OMEGA_SQ_RST, DAMPING_TERM_RST, SAMPLE_PERIOD_RST, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct <= 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct <= 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int seg = 0; seg < PHASE_SEGMENTS; seg++) begin
        if (seg != 0) random_settings();
        if (seg == 2) begin
          // output held off while the sender keeps offering: input stalls
          saved_idle    = send_idle_pct;
          send_idle_pct = 0;
          hold_req <= ~hold_req;
          repeat (BURST_ITEMS) send_random();
          send_idle_pct = saved_idle;
        end
        repeat (SEGMENT_ITEMS) send_random();
        drain();
      end
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && estimates_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
